// File: rtl/core/smart_card_atr_parser_top_defines.svh
// Assertion macros for the ATR parser
`ifndef SMART_CARD_ATR_PARSER_TOP_DEFINES_SVH
`define SMART_CARD_ATR_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ATR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ATR parser assertion failed");

// condition must never be seen outside reset
`define ATR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ATR parser forbidden condition seen");

`else

`define ATR_ASSERT(label, clk, rst_n, prop)
`define ATR_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/core/scatr_pkg.sv
package scatr_pkg;

    // item kinds on the input side
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;

    // result status codes
    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_BAD_TS    = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_RX_FAIL   = 3'd5;
    localparam logic [2:0] ST_NOT_ARMED = 3'd6;

    // byte roles
    localparam logic [3:0] ROLE_TS   = 4'd0;
    localparam logic [3:0] ROLE_T0   = 4'd1;
    localparam logic [3:0] ROLE_TA   = 4'd2;
    localparam logic [3:0] ROLE_HIST = 4'd6;
    localparam logic [3:0] ROLE_TCK  = 4'd7;
    localparam logic [3:0] ROLE_NONE = 4'd8;

    // TS values
    localparam logic [7:0] TS_DIRECT     = 8'h3B;
    localparam logic [7:0] TS_INVERSE    = 8'h03;
    localparam logic [7:0] TS_INVERSE_ST = 8'h3F;

    localparam logic [7:0] LIMIT_RESET = 8'd33;
    localparam logic [7:0] LIMIT_MIN   = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TS,
        PH_T0,
        PH_IFACE,
        PH_HIST,
        PH_TCK
    } phase_t;

    // parser state carried from byte to byte
    typedef struct packed {
        phase_t     phase;
        logic [3:0] ind;        // indicator bits still expected (TA..TD)
        logic [2:0] bits_left;
        logic [3:0] grp_idx;
        logic [3:0] hist_left;
        logic [3:0] hist_total;
        logic       chk;
        logic [7:0] xsum;
        logic [7:0] count;
        logic       rev;
    } atr_state_t;

    // one result item
    typedef struct packed {
        logic [3:0] hist;
        logic [4:0] pgroups;
        logic [7:0] count;
        logic       rev;
        logic [7:0] stored;
        logic [3:0] grp;
        logic [3:0] role;
        logic [2:0] status;
    } atr_result_t;

endpackage

// File: rtl/core/smart_card_atr_parser_top.sv
// Channel   Dir  tdata (low bit first)                                   tuser
// s_axis    in   rx_byte[7:0]                                            kind[1:0]
// m_axis    out  status, group_number, stored_byte, reverse_convention,  byte_role[3:0]
//                byte_count, protocol_groups, historical_count, pad
// cfg       in   cfg_wdata = length_limit, written when cfg_we is high
//
// One item per clock unless the output stalls: the parse step is a single pass of logic
// from the state register to the result register, so a result shows in the cycle after its item.
// s_axis_tready is low only while a result is held and m_axis_tready is low.
// rst_n (asynchronous) disarms the parser and sets length_limit to 33.
`include "smart_card_atr_parser_top_defines.svh"

module smart_card_atr_parser_top
    import scatr_pkg::*;
#(
    parameter int MAX_GROUPS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], group_number[6:3], stored_byte[14:7], reverse_convention[15],
    // byte_count[23:16], protocol_groups[28:24], historical_count[32:29], zeros
    output logic [39:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser    // byte_role[3:0]
);

    logic [7:0]  limit_reg;
    atr_state_t  atr_reg;
    atr_state_t  atr_next;
    atr_result_t res_next;
    atr_result_t res_reg;
    logic        out_valid_reg;
    logic        in_fire;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    scatr_step #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_step (
        .kind         (s_axis_tuser),
        .rx_byte      (s_axis_tdata),
        .length_limit (limit_reg),
        .cur          (atr_reg),
        .nxt          (atr_next),
        .res          (res_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            atr_reg <= '0;
        else if (in_fire)
            atr_reg <= atr_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.role;
    assign m_axis_tdata  = {7'b0, res_reg.hist, res_reg.pgroups, res_reg.count, res_reg.rev,
                            res_reg.stored, res_reg.grp, res_reg.status};

    // checks
    `ATR_ASSERT(a_final_disarms, clk, rst_n, (in_fire && res_next.status != ST_PROGRESS) |=> (atr_reg.phase == PH_IDLE))
    `ATR_NEVER(a_grp_bound, clk, rst_n, ({1'b0, atr_reg.grp_idx} > 5'(MAX_GROUPS)))
    `ATR_NEVER(a_bits_left_bound, clk, rst_n, (atr_reg.bits_left > 3'd4))
    `ATR_ASSERT(a_item_gives_result, clk, rst_n, in_fire |=> m_axis_tvalid)
    `ATR_ASSERT(a_count_step, clk, rst_n, (in_fire && s_axis_tuser == KIND_BYTE && atr_reg.phase != PH_IDLE) |=> (atr_reg.count == 8'($past(atr_reg.count) + 8'd1)))

endmodule

// File: rtl/core/scatr_step.sv
module scatr_step
    import scatr_pkg::*;
#(
    parameter int MAX_GROUPS = 8
)
(
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  length_limit,
    input  atr_state_t  cur,
    output atr_state_t  nxt,
    output atr_result_t res
);

    localparam logic [4:0] MaxGrp = 5'(MAX_GROUPS);

    typedef struct packed {
        logic [2:0] status;
        phase_t     phase;
    } chunk_t;

    function automatic logic [2:0] pop4(input logic [3:0] v);
        return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

    // would a chunk of 'more' bytes keep the count within the limit
    function automatic logic fits(input logic [7:0] cnt, input logic [3:0] more,
                                  input logic [7:0] lim);
        return ({1'b0, cnt} + {5'b0, more}) <= {1'b0, lim};
    endfunction

    function automatic chunk_t after_hist(input logic chk, input logic [7:0] cnt,
                                          input logic [7:0] lim);
        chunk_t r;
        r.phase  = PH_IDLE;
        r.status = ST_COMPLETE;
        if (chk)
        begin
            if (fits(cnt, 4'd1, lim))
            begin
                r.status = ST_PROGRESS;
                r.phase  = PH_TCK;
            end
            else
                r.status = ST_TOO_LONG;
        end
        return r;
    endfunction

    function automatic chunk_t after_iface(input logic [3:0] hist, input logic chk,
                                           input logic [7:0] cnt, input logic [7:0] lim);
        chunk_t r;
        r.phase  = PH_IDLE;
        r.status = ST_TOO_LONG;
        if (hist != 4'd0)
        begin
            if (fits(cnt, hist, lim))
            begin
                r.status = ST_PROGRESS;
                r.phase  = PH_HIST;
            end
        end
        else
            r = after_hist(chk, cnt, lim);
        return r;
    endfunction

    function automatic chunk_t start_group(input logic [3:0] ind, input logic [3:0] hist,
                                           input logic chk, input logic [7:0] cnt,
                                           input logic [7:0] lim);
        chunk_t     r;
        logic [2:0] n;
        n        = pop4(ind);
        r.phase  = PH_IDLE;
        r.status = ST_TOO_LONG;
        if (n == 3'd0)
            r = after_iface(hist, chk, cnt, lim);
        else if (fits(cnt, {1'b0, n}, lim))
        begin
            r.status = ST_PROGRESS;
            r.phase  = PH_IFACE;
        end
        return r;
    endfunction

    // one pass over the current byte
    always_comb
    begin
        logic [2:0] st;
        logic [3:0] role;
        logic [3:0] grp;
        logic [7:0] stored;
        logic [7:0] cnt_new;
        logic [7:0] xnew;
        logic [1:0] pos;
        logic       chk_new;
        chunk_t     r;

        nxt     = cur;
        st      = ST_PROGRESS;
        role    = ROLE_NONE;
        grp     = '0;
        stored  = '0;
        cnt_new = cur.count + 8'd1;
        xnew    = cur.xsum ^ rx_byte;
        pos     = 2'd3;
        chk_new = cur.chk;
        r       = '{status: ST_PROGRESS, phase: PH_IDLE};

        case (kind)
            KIND_START:
            begin
                nxt       = '0;
                nxt.phase = PH_TS;
                if (length_limit < LIMIT_MIN)
                    st = ST_TOO_LONG;
            end
            KIND_BYTE:
            begin
                if (cur.phase == PH_IDLE)
                    st = ST_NOT_ARMED;
                else
                begin
                    nxt.count = cnt_new;
                    stored    = rx_byte;
                    case (cur.phase)
                        PH_TS:
                        begin
                            role = ROLE_TS;
                            if (rx_byte == TS_DIRECT)
                                nxt.phase = PH_T0;
                            else if (rx_byte == TS_INVERSE)
                            begin
                                nxt.rev   = 1'b1;
                                stored    = TS_INVERSE_ST;
                                nxt.phase = PH_T0;
                            end
                            else
                                st = ST_BAD_TS;
                        end
                        PH_T0:
                        begin
                            role           = ROLE_T0;
                            nxt.xsum       = rx_byte;
                            nxt.hist_total = rx_byte[3:0];
                            nxt.ind        = rx_byte[7:4];
                            nxt.bits_left  = pop4(rx_byte[7:4]);
                            r = start_group(rx_byte[7:4], rx_byte[3:0], cur.chk, cnt_new,
                                            length_limit);
                            st        = r.status;
                            nxt.phase = r.phase;
                            nxt.hist_left = rx_byte[3:0];
                        end
                        PH_IFACE:
                        begin
                            // lowest pending indicator bit names the byte
                            if (cur.ind[0])
                                pos = 2'd0;
                            else if (cur.ind[1])
                                pos = 2'd1;
                            else if (cur.ind[2])
                                pos = 2'd2;
                            role     = ROLE_TA + {2'b00, pos};
                            grp      = cur.grp_idx;
                            nxt.xsum = xnew;
                            nxt.ind  = cur.ind & ~(4'b0001 << pos);
                            if (cur.bits_left != 3'd0)
                                nxt.bits_left = cur.bits_left - 3'd1;
                            nxt.hist_left = cur.hist_total;
                            if (pos == 2'd3)
                            begin
                                // TD: maybe a further group, TCK when protocol not T=0
                                chk_new = cur.chk | (rx_byte[3:0] != 4'd0);
                                nxt.chk = chk_new;
                                if (({1'b0, cur.grp_idx} + 5'd1) > MaxGrp)
                                    st = ST_MALFORMED;
                                else
                                begin
                                    nxt.grp_idx   = cur.grp_idx + 4'd1;
                                    nxt.ind       = rx_byte[7:4];
                                    nxt.bits_left = pop4(rx_byte[7:4]);
                                    r = start_group(rx_byte[7:4], cur.hist_total, chk_new,
                                                    cnt_new, length_limit);
                                    st        = r.status;
                                    nxt.phase = r.phase;
                                end
                            end
                            else if (nxt.bits_left == 3'd0)
                            begin
                                r = after_iface(cur.hist_total, cur.chk, cnt_new,
                                                length_limit);
                                st        = r.status;
                                nxt.phase = r.phase;
                            end
                        end
                        PH_HIST:
                        begin
                            role     = ROLE_HIST;
                            nxt.xsum = xnew;
                            if (cur.hist_left != 4'd0)
                                nxt.hist_left = cur.hist_left - 4'd1;
                            if (nxt.hist_left == 4'd0)
                            begin
                                r         = after_hist(cur.chk, cnt_new, length_limit);
                                st        = r.status;
                                nxt.phase = r.phase;
                            end
                        end
                        PH_TCK:
                        begin
                            role     = ROLE_TCK;
                            nxt.xsum = xnew;
                            st       = (xnew == 8'd0) ? ST_COMPLETE : ST_MALFORMED;
                        end
                        default:
                        begin
                            st = ST_NOT_ARMED;
                        end
                    endcase
                end
            end
            default:
            begin
                // receive failure (and the unused kind)
                st = (cur.phase == PH_IDLE) ? ST_NOT_ARMED : ST_RX_FAIL;
            end
        endcase

        // any final status disarms the parser
        if (st != ST_PROGRESS)
            nxt.phase = PH_IDLE;

        res.status  = st;
        res.role    = role;
        res.grp     = grp;
        res.stored  = stored;
        res.rev     = nxt.rev;
        res.count   = nxt.count;
        res.pgroups = (st == ST_COMPLETE) ? ({1'b0, nxt.grp_idx} + 5'd1) : 5'd0;
        res.hist    = nxt.hist_total;
    end

endmodule
